[hw/rtl/vrrf_pkg.sv]
// ----------------------------------------------------------------------------
// Variable record ring FIFO package
// Shared constants, request and status codes, and register indexes.
// ----------------------------------------------------------------------------
package vrrf_pkg;

    // Default sizes for the top level parameters and the ring size after reset.
    localparam int RING_CAPACITY_DEF = 4096;
    localparam int MAX_RECORD_DEF    = 64;
    localparam int RING_BYTES_RESET  = 4096;

    // Fixed field widths.
    localparam int REQ_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 6;
    localparam int STAT_W    = 2;
    localparam int CNT_W     = 13;
    localparam int CFG_DW    = 13;
    localparam int CFG_IDX_W = 2;

    // Bytes of the little-endian length prefix in variable mode.
    localparam int PREFIX_BYTES = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEQUEUE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FRONT   = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_STORED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
    localparam logic [STAT_W-1:0] ST_DATA     = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RING_BYTES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIXED_BYTES = 2'd1;

endpackage

[hw/rtl/vrrf_ram.sv]
// ----------------------------------------------------------------------------
// Variable record ring FIFO byte store
// Single-port synchronous RAM, read-first, with a registered read.
// ----------------------------------------------------------------------------
module vrrf_ram #(
    parameter int DEPTH = 4096,
    parameter int DW    = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DW-1:0]            i_wdata,
    output logic [DW-1:0]            o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/variable_record_ring_fifo_top.sv]
// ----------------------------------------------------------------------------
// Variable record ring FIFO
// Byte ring holding whole records, fixed size or led by a 2-byte length.
// ----------------------------------------------------------------------------
//
// Channel    | Direction | Handshake                       | Payload
// -----------+-----------+---------------------------------+---------------------------
// request    | in        | start high while busy low       | req_type, data_byte,
//            |           |                                 | record_length
// result     | out       | o_result_valid, one cycle each  | status, out_byte, length,
//            |           |                                 | last, count, used, free
// config     | in        | i_cfg_valid and o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A pushed byte is written from S_IDLE, except the first byte of a
// variable-length record that fits, which goes through S_PFX and S_WDATA as the
// two prefix bytes and the data byte share the single memory port; a rejected
// first byte is handled in S_IDLE. Dequeue and front read the prefix in S_RLEN
// and then one byte per read in S_RDATA in variable mode, and go straight to
// S_RDATA in fixed mode; an empty queue answers from S_IDLE. Reset is synchronous
// and needs no clearing pass. Results cannot be stalled by the receiver.
//
module variable_record_ring_fifo_top #(
    parameter int RING_CAPACITY    = vrrf_pkg::RING_CAPACITY_DEF,
    parameter int MAX_RECORD_BYTES = vrrf_pkg::MAX_RECORD_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [vrrf_pkg::REQ_W-1:0]      i_req_type,
    input  logic [vrrf_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic [vrrf_pkg::LEN_W-1:0]      i_record_length,
    output logic                            o_result_valid,
    output logic [vrrf_pkg::STAT_W-1:0]     o_status,
    output logic [vrrf_pkg::BYTE_W-1:0]     o_out_byte,
    output logic [vrrf_pkg::LEN_W-1:0]      o_out_length,
    output logic                            o_last_byte,
    output logic [vrrf_pkg::CNT_W-1:0]      o_record_count,
    output logic [vrrf_pkg::CNT_W-1:0]      o_used_bytes,
    output logic [vrrf_pkg::CNT_W-1:0]      o_free_bytes,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vrrf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vrrf_pkg::CFG_DW-1:0]     i_cfg_data
);

    import vrrf_pkg::*;

    localparam int AW = $clog2(RING_CAPACITY);
    localparam int CW = AW + 1;
    localparam int SW = CW + 1;
    localparam int XW = (CW > LEN_W + 1) ? CW : LEN_W + 1;
    localparam int RING_RESET = (RING_BYTES_RESET > RING_CAPACITY) ?
                                RING_CAPACITY : RING_BYTES_RESET;
    localparam logic [LEN_W:0] MAX_LEN = (LEN_W + 1)'(MAX_RECORD_BYTES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PFX   = 5'b00010,
        S_WDATA = 5'b00100,
        S_RLEN  = 5'b01000,
        S_RDATA = 5'b10000
    } t_state;

    // Adds k (at most 2) to a ring position and wraps at the ring size.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                               input logic [CW-1:0] ring,
                                               input logic [1:0]    k);
        logic [SW-1:0] s;
        s = SW'(p) + SW'(k);
        if (s >= SW'(ring)) begin
            s = s - SW'(ring);
        end
        return s[AW-1:0];
    endfunction

    t_state               r_state, n_state;
    logic [CW-1:0]        r_ring, n_ring;
    logic [LEN_W-1:0]     r_fixed, n_fixed;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_tail, n_tail;
    logic [AW-1:0]        r_wcur, n_wcur;
    logic [AW-1:0]        r_rpos, n_rpos;
    logic [CW-1:0]        r_records, n_records;
    logic [CW-1:0]        r_occ, n_occ;
    logic [CW-1:0]        r_used, n_used;
    logic [LEN_W-1:0]     r_togo, n_togo;
    logic                 r_drop, n_drop;
    logic [LEN_W-1:0]     r_open_len, n_open_len;
    logic [BYTE_W-1:0]    r_hold, n_hold;
    logic [LEN_W-1:0]     r_rlen, n_rlen;
    logic [LEN_W-1:0]     r_ecnt, n_ecnt;
    logic                 r_remove, n_remove;
    logic                 r_ov, n_ov;
    logic [STAT_W-1:0]    r_ostat, n_ostat;
    logic [BYTE_W-1:0]    r_obyte, n_obyte;
    logic [LEN_W-1:0]     r_olen, n_olen;
    logic                 r_olast, n_olast;

    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [BYTE_W-1:0]    mem_wdata;
    logic [BYTE_W-1:0]    mem_rdata;

    logic                 accept;
    logic                 cfg_fire;
    logic [1:0]           pre_len;
    logic [CW-1:0]        gross;
    logic [CW-1:0]        free_bytes;
    logic [LEN_W-1:0]     len_in;
    logic                 len_ok;
    logic [LEN_W-1:0]     rd_len;

    // Shared data-byte write, used by the first and later bytes of a record.
    logic                 w_go;
    logic [AW-1:0]        w_addr;
    logic [BYTE_W-1:0]    w_byte;
    logic [LEN_W-1:0]     w_togo;
    logic [LEN_W-1:0]     w_len;

    vrrf_ram #(
        .DEPTH (RING_CAPACITY),
        .DW    (BYTE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign accept      = start && !busy;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    assign pre_len    = (r_fixed == '0) ? 2'(PREFIX_BYTES) : 2'd0;
    assign gross      = r_ring - r_occ;
    assign free_bytes = (gross <= CW'(pre_len)) ? '0 : gross - CW'(pre_len);
    assign len_in     = (r_fixed != '0) ? r_fixed : i_record_length;
    assign len_ok     = ({1'b0, len_in} < MAX_LEN) && (XW'(len_in) <= XW'(free_bytes));
    assign rd_len     = mem_rdata[LEN_W-1:0];

    always_comb begin
        n_state    = r_state;
        n_ring     = r_ring;
        n_fixed    = r_fixed;
        n_head     = r_head;
        n_tail     = r_tail;
        n_wcur     = r_wcur;
        n_rpos     = r_rpos;
        n_records  = r_records;
        n_occ      = r_occ;
        n_used     = r_used;
        n_togo     = r_togo;
        n_drop     = r_drop;
        n_open_len = r_open_len;
        n_hold     = r_hold;
        n_rlen     = r_rlen;
        n_ecnt     = r_ecnt;
        n_remove   = r_remove;
        n_ov       = 1'b0;
        n_ostat    = r_ostat;
        n_obyte    = r_obyte;
        n_olen     = r_olen;
        n_olast    = r_olast;
        mem_we     = 1'b0;
        mem_addr   = r_wcur;
        mem_wdata  = r_hold;
        w_go       = 1'b0;
        w_addr     = r_wcur;
        w_byte     = i_data_byte;
        w_togo     = r_togo;
        w_len      = r_open_len;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_PUSH: begin
                            if (r_togo == '0) begin
                                if (len_in == '0) begin
                                    n_ov    = 1'b1;
                                    n_ostat = ST_REJECTED;
                                    n_obyte = '0;
                                    n_olen  = '0;
                                    n_olast = 1'b1;
                                end else if (!len_ok) begin
                                    // Swallow the record; only its last byte reports.
                                    n_open_len = len_in;
                                    n_drop     = 1'b1;
                                    n_togo     = len_in - LEN_W'(1);
                                    if (len_in == LEN_W'(1)) begin
                                        n_drop  = 1'b0;
                                        n_ov    = 1'b1;
                                        n_ostat = ST_REJECTED;
                                        n_obyte = '0;
                                        n_olen  = len_in;
                                        n_olast = 1'b1;
                                    end
                                end else if (r_fixed != '0) begin
                                    n_open_len = len_in;
                                    n_drop     = 1'b0;
                                    w_go       = 1'b1;
                                    w_addr     = r_tail;
                                    w_togo     = len_in;
                                    w_len      = len_in;
                                end else begin
                                    // Low prefix byte now, high byte and data follow.
                                    n_open_len = len_in;
                                    n_drop     = 1'b0;
                                    mem_we     = 1'b1;
                                    mem_addr   = r_tail;
                                    mem_wdata  = BYTE_W'(len_in);
                                    n_wcur     = wrap_add(r_tail, r_ring, 2'd1);
                                    n_hold     = i_data_byte;
                                    n_togo     = len_in;
                                    n_state    = S_PFX;
                                end
                            end else if (r_drop) begin
                                n_togo = r_togo - LEN_W'(1);
                                if (r_togo == LEN_W'(1)) begin
                                    n_drop  = 1'b0;
                                    n_ov    = 1'b1;
                                    n_ostat = ST_REJECTED;
                                    n_obyte = '0;
                                    n_olen  = r_open_len;
                                    n_olast = 1'b1;
                                end
                            end else begin
                                w_go = 1'b1;
                            end
                        end
                        REQ_DEQUEUE, REQ_FRONT: begin
                            n_remove = (i_req_type == REQ_DEQUEUE);
                            if (r_records == '0) begin
                                n_ov    = 1'b1;
                                n_ostat = ST_EMPTY;
                                n_obyte = '0;
                                n_olen  = '0;
                                n_olast = 1'b1;
                            end else if (r_fixed == '0) begin
                                mem_addr = r_head;
                                n_rpos   = wrap_add(r_head, r_ring, 2'(PREFIX_BYTES));
                                n_state  = S_RLEN;
                            end else begin
                                mem_addr = r_head;
                                n_rpos   = wrap_add(r_head, r_ring, 2'd1);
                                n_rlen   = r_fixed;
                                n_ecnt   = '0;
                                if (i_req_type == REQ_DEQUEUE) begin
                                    n_records = r_records - CW'(1);
                                    n_occ     = r_occ - CW'(r_fixed);
                                    n_used    = r_used - CW'(r_fixed);
                                end
                                n_state = S_RDATA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PFX: begin
                mem_we    = 1'b1;
                mem_addr  = r_wcur;
                mem_wdata = '0;
                n_wcur    = wrap_add(r_wcur, r_ring, 2'd1);
                n_state   = S_WDATA;
            end
            S_WDATA: begin
                w_go    = 1'b1;
                w_byte  = r_hold;
                n_state = S_IDLE;
            end
            S_RLEN: begin
                n_rlen = rd_len;
                n_ecnt = '0;
                if (r_remove) begin
                    n_records = r_records - CW'(1);
                    n_occ     = r_occ - CW'(rd_len) - CW'(PREFIX_BYTES);
                    n_used    = r_used - CW'(rd_len);
                end
                if (rd_len == '0) begin
                    n_ov    = 1'b1;
                    n_ostat = ST_EMPTY;
                    n_obyte = '0;
                    n_olen  = '0;
                    n_olast = 1'b1;
                    if (r_remove) begin
                        n_head = r_rpos;
                    end
                    n_state = S_IDLE;
                end else begin
                    mem_addr = r_rpos;
                    n_rpos   = wrap_add(r_rpos, r_ring, 2'd1);
                    n_state  = S_RDATA;
                end
            end
            S_RDATA: begin
                // Shows the byte read before; a further read is issued unless this is the last.
                n_ov    = 1'b1;
                n_ostat = ST_DATA;
                n_obyte = mem_rdata;
                n_olen  = r_rlen;
                n_olast = (r_ecnt + LEN_W'(1) == r_rlen);
                n_ecnt  = r_ecnt + LEN_W'(1);
                if (r_ecnt + LEN_W'(1) == r_rlen) begin
                    if (r_remove) begin
                        n_head = r_rpos;
                    end
                    n_state = S_IDLE;
                end else begin
                    mem_addr = r_rpos;
                    n_rpos   = wrap_add(r_rpos, r_ring, 2'd1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_go) begin
            mem_we    = 1'b1;
            mem_addr  = w_addr;
            mem_wdata = w_byte;
            n_wcur    = wrap_add(w_addr, r_ring, 2'd1);
            n_togo    = w_togo - LEN_W'(1);
            if (w_togo == LEN_W'(1)) begin
                // Last byte: commit the record.
                n_tail    = wrap_add(w_addr, r_ring, 2'd1);
                n_records = r_records + CW'(1);
                n_occ     = r_occ + CW'(w_len) + CW'(pre_len);
                n_used    = r_used + CW'(w_len);
                n_ov      = 1'b1;
                n_ostat   = ST_STORED;
                n_obyte   = '0;
                n_olen    = w_len;
                n_olast   = 1'b1;
            end
        end

        if (cfg_fire) begin
            case (i_cfg_index)
                REG_RING_BYTES: begin
                    if (32'(i_cfg_data) < 32'd4) begin
                        n_ring = CW'(4);
                    end else if (32'(i_cfg_data) > 32'(RING_CAPACITY)) begin
                        n_ring = CW'(RING_CAPACITY);
                    end else begin
                        n_ring = CW'(i_cfg_data);
                    end
                end
                REG_FIXED_BYTES: begin
                    n_fixed = i_cfg_data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
            if (i_cfg_index == REG_RING_BYTES || i_cfg_index == REG_FIXED_BYTES) begin
                // A write to either configuration register empties the queue and drops an open record.
                n_head     = '0;
                n_tail     = '0;
                n_wcur     = '0;
                n_records  = '0;
                n_occ      = '0;
                n_used     = '0;
                n_togo     = '0;
                n_drop     = 1'b0;
                n_open_len = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ring     <= CW'(RING_RESET);
            r_fixed    <= '0;
            r_head     <= '0;
            r_tail     <= '0;
            r_wcur     <= '0;
            r_records  <= '0;
            r_occ      <= '0;
            r_used     <= '0;
            r_togo     <= '0;
            r_drop     <= 1'b0;
            r_open_len <= '0;
            r_remove   <= 1'b0;
            r_ecnt     <= '0;
            r_ov       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ring     <= n_ring;
            r_fixed    <= n_fixed;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_wcur     <= n_wcur;
            r_records  <= n_records;
            r_occ      <= n_occ;
            r_used     <= n_used;
            r_togo     <= n_togo;
            r_drop     <= n_drop;
            r_open_len <= n_open_len;
            r_remove   <= n_remove;
            r_ecnt     <= n_ecnt;
            r_ov       <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rpos  <= n_rpos;
        r_hold  <= n_hold;
        r_rlen  <= n_rlen;
        r_ostat <= n_ostat;
        r_obyte <= n_obyte;
        r_olen  <= n_olen;
        r_olast <= n_olast;
    end

    // Counts reflect the state after the transaction that caused the result.
    assign o_result_valid = r_ov;
    assign o_status       = r_ostat;
    assign o_out_byte     = r_obyte;
    assign o_out_length   = r_olen;
    assign o_last_byte    = r_olast;
    assign o_record_count = CNT_W'(r_records);
    assign o_used_bytes   = CNT_W'(r_used);
    assign o_free_bytes   = CNT_W'(free_bytes);

endmodule
